@@ sv/oale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_pkg
// Shared request codes, status codes and the result word of the list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_LOCATE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         found_position;
		logic signed [31:0] removed_value;
		logic [4:0]         list_length;
	} oale_res_t;

endpackage

@@ sv/oale_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module oale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/oale_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_ctrl
// Request sequencer: checks the position, walks the store one entry per
// cycle through the RAM port and holds the length count and the result.
// ----------------------------------------------------------------------------
module oale_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  position,
	input  logic signed [31:0]          value,
	output logic                        busy,
	output logic                        res_valid,
	input  logic                        res_take,
	output oale_pkg::oale_res_t         res,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output logic [31:0]                 ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  logic [31:0]                 ram_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_LOC,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      walk_q;
	logic [AW-1:0]      stop_q;
	logic               issuing_q;
	logic               first_q;
	logic               pend_s1;
	logic               first_s1;
	logic [AW-1:0]      paddr_s1;
	logic [31:0]        val_q;
	logic [1:0]         status_q;
	logic [XW-1:0]      found_q;
	logic signed [31:0] removed_q;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          ins_bad;
	logic          ins_full;
	logic          ins_append;
	logic          del_bad;

	assign pos_x      = XW'(position);
	assign cnt_x      = XW'(count_q);
	assign ins_bad    = (position == 8'd0) || (pos_x > cnt_x + XW'(1));
	assign ins_full   = (count_q == CW'(CAPACITY));
	assign ins_append = (pos_x == cnt_x + XW'(1));
	assign del_bad    = (position == 8'd0) || (pos_x > cnt_x);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);

	assign res.status         = status_q;
	assign res.found_position = 5'(found_q);
	assign res.removed_value  = removed_q;
	assign res.list_length    = 5'(count_q);

	// read side of the walk, one entry a cycle
	assign ram_re    = issuing_q && (state_q == S_INS || state_q == S_DEL || state_q == S_LOC);
	assign ram_raddr = walk_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = paddr_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_IDLE: begin
				if (start && req_type == oale_pkg::REQ_INSERT && !ins_bad && !ins_full
						&& ins_append) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(count_q);
					ram_wdata = value;
				end
			end
			S_INS: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = paddr_s1 + AW'(1);
				end else if (!issuing_q) begin
					// shift done, drop the new word into its slot
					ram_we    = 1'b1;
					ram_waddr = stop_q;
					ram_wdata = val_q;
				end
			end
			S_DEL: begin
				if (pend_s1 && !first_s1) begin
					ram_we    = 1'b1;
					ram_waddr = paddr_s1 - AW'(1);
				end
			end
			S_LOC, S_FIN: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			issuing_q <= 1'b0;
			pend_s1   <= 1'b0;
			first_q   <= 1'b0;
			first_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						val_q     <= value;
						found_q   <= '0;
						removed_q <= '0;
						status_q  <= oale_pkg::ST_OK;
						first_q   <= 1'b1;
						unique case (req_type)
							oale_pkg::REQ_INSERT: begin
								if (ins_bad) begin
									status_q <= oale_pkg::ST_BADPOS;
									state_q  <= S_FIN;
								end else if (ins_full) begin
									status_q <= oale_pkg::ST_FULL;
									state_q  <= S_FIN;
								end else if (ins_append) begin
									count_q <= count_q + CW'(1);
									state_q <= S_FIN;
								end else begin
									walk_q    <= AW'(cnt_x - XW'(1));
									stop_q    <= AW'(pos_x - XW'(1));
									issuing_q <= 1'b1;
									state_q   <= S_INS;
								end
							end
							oale_pkg::REQ_DELETE: begin
								if (del_bad) begin
									status_q <= oale_pkg::ST_BADPOS;
									state_q  <= S_FIN;
								end else begin
									walk_q    <= AW'(pos_x - XW'(1));
									stop_q    <= AW'(cnt_x - XW'(1));
									issuing_q <= 1'b1;
									state_q   <= S_DEL;
								end
							end
							oale_pkg::REQ_LOCATE: begin
								if (count_q == '0) begin
									status_q <= oale_pkg::ST_MISSING;
									state_q  <= S_FIN;
								end else begin
									walk_q    <= '0;
									stop_q    <= AW'(cnt_x - XW'(1));
									issuing_q <= 1'b1;
									state_q   <= S_LOC;
								end
							end
							default: begin
								status_q <= oale_pkg::ST_BADPOS;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_INS, S_DEL, S_LOC: begin
					pend_s1  <= issuing_q;
					paddr_s1 <= walk_q;
					first_s1 <= first_q;
					if (issuing_q) begin
						first_q <= 1'b0;
						if (walk_q == stop_q) begin
							issuing_q <= 1'b0;
						end else if (state_q == S_INS) begin
							walk_q <= walk_q - AW'(1);
						end else begin
							walk_q <= walk_q + AW'(1);
						end
					end
					if (state_q == S_INS) begin
						if (!issuing_q && !pend_s1) begin
							count_q <= count_q + CW'(1);
							state_q <= S_FIN;
						end
					end else if (state_q == S_DEL) begin
						if (pend_s1 && first_s1) begin
							removed_q <= ram_rdata;
						end
						if (!issuing_q && !pend_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= S_FIN;
						end
					end else begin
						if (pend_s1 && ram_rdata == val_q) begin
							found_q   <= XW'(paddr_s1) + XW'(1);
							issuing_q <= 1'b0;
							state_q   <= S_FIN;
						end else if (pend_s1 && !issuing_q) begin
							status_q <= oale_pkg::ST_MISSING;
							state_q  <= S_FIN;
						end
					end
				end
				S_FIN: begin
					pend_s1   <= 1'b0;
					issuing_q <= 1'b0;
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/ordered_array_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Positional list of signed 32-bit words in one RAM with a length count:
// insert at a position, delete at a position, locate a value.
// ----------------------------------------------------------------------------
//  channel | ports                                       | moves
//  --------+---------------------------------------------+---------------------
//  in      | in_valid, in_stall, req_type, position,     | one request word
//          | value                                       |
//  out     | out_valid, out_stall, status,               | one result word
//          | found_position, removed_value, list_length  | per request
//
// requests run one at a time; the walk reads one RAM entry per cycle.
// insert at p shifts entries p..n up, then writes p; an append writes directly.
// delete at p shifts the later entries down; locate walks to the first match.
// the result register lets the next request start while a result is stalled.
// reset clears the length count and the state; the store is not cleared, no init pass.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [4:0]         found_position,
	output logic signed [31:0] removed_value,
	output logic [4:0]         list_length
);

	localparam int AW = $clog2(CAPACITY);

	logic                busy;
	logic                res_valid;
	logic                res_take;
	oale_pkg::oale_res_t res;
	oale_pkg::oale_res_t out_q;
	logic                out_valid_q;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [31:0]         ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [31:0]         ram_rdata;

	assign in_stall = busy;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	oale_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && !busy),
		.req_type (req_type),
		.position (position),
		.value    (value),
		.busy     (busy),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	oale_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign found_position = out_q.found_position;
	assign removed_value  = out_q.removed_value;
	assign list_length    = out_q.list_length;

endmodule

@@ sv/oale_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module oale_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [4:0]         found_position,
	input logic signed [31:0] removed_value
);

	// one request at a time: the engine is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a request was still running");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != oale_pkg::ST_OK) |-> (found_position == 5'd0
			&& removed_value == 32'sd0))
		else $error("failed request carries a position or removed word");

	a_found_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_position != 5'd0) |-> (status == oale_pkg::ST_OK
			&& removed_value == 32'sd0))
		else $error("found position with a bad status or removed word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)
			&& $stable(found_position) && $stable(removed_value)))
		else $error("stalled result word changed");

endmodule

bind ordered_array_list_engine_unit oale_checker u_oale_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.found_position(found_position),
	.removed_value (removed_value)
);

@@ tb/sv/tb_ordered_array_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine_unit
// Drives insert, delete and locate requests into the list engine with bursty
// request timing and a changing stall pattern on the result side. A shadow
// copy of the list predicts every result word, and each one is checked field
// by field in order.
// ----------------------------------------------------------------------------
class list_scoreboard #(int DEPTH = 16);
	logic signed [31:0]  entries [DEPTH];
	int unsigned         count;
	oale_pkg::oale_res_t expected_q [$];
	int unsigned         errors;
	int unsigned         checked;
	int unsigned         kind_seen [4];
	int unsigned         status_seen [4];
	int unsigned         peak_len;

	function new();
		count = 0;
		errors = 0;
		checked = 0;
		peak_len = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (entries[i]) entries[i] = '0;
	endfunction

	// update the shadow list and queue the result word this request should give
	function void note_request(logic [1:0] kind, logic [7:0] pos, logic signed [31:0] val);
		oale_pkg::oale_res_t exp_word;
		int                  k;
		exp_word = '0;
		kind_seen[kind]++;
		case (kind)
			oale_pkg::REQ_INSERT: begin
				if (pos < 1 || pos > count + 1) begin
					exp_word.status = oale_pkg::ST_BADPOS;
				end else if (count >= DEPTH) begin
					exp_word.status = oale_pkg::ST_FULL;
				end else begin
					for (k = count; k >= pos; k--)
						entries[k] = entries[k-1];
					entries[pos-1] = val;
					count++;
					exp_word.status = oale_pkg::ST_OK;
				end
			end
			oale_pkg::REQ_DELETE: begin
				if (pos < 1 || pos > count) begin
					exp_word.status = oale_pkg::ST_BADPOS;
				end else begin
					exp_word.removed_value = entries[pos-1];
					for (k = pos; k < count; k++)
						entries[k-1] = entries[k];
					count--;
					exp_word.status = oale_pkg::ST_OK;
				end
			end
			oale_pkg::REQ_LOCATE: begin
				exp_word.status = oale_pkg::ST_MISSING;
				for (k = 0; k < count; k++) begin
					if (entries[k] == val) begin
						exp_word.status = oale_pkg::ST_OK;
						exp_word.found_position = 5'(k + 1);
						break;
					end
				end
			end
			default: begin
				exp_word.status = oale_pkg::ST_BADPOS;
			end
		endcase
		exp_word.list_length = 5'(count);
		if (count > peak_len)
			peak_len = count;
		expected_q.push_back(exp_word);
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_result(oale_pkg::oale_res_t got);
		oale_pkg::oale_res_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("result word with nothing pending (status %0d)",
				got.status));
			return;
		end
		want = expected_q.pop_front();
		checked++;
		status_seen[want.status]++;
		if (got.status !== want.status)
			report_mismatch($sformatf("word %0d status %0d, want %0d",
				checked, got.status, want.status));
		if (got.found_position !== want.found_position)
			report_mismatch($sformatf("word %0d found_position %0d, want %0d",
				checked, got.found_position, want.found_position));
		if (got.removed_value !== want.removed_value)
			report_mismatch($sformatf("word %0d removed_value %0d, want %0d",
				checked, got.removed_value, want.removed_value));
		if (got.list_length !== want.list_length)
			report_mismatch($sformatf("word %0d list_length %0d, want %0d",
				checked, got.list_length, want.list_length));
	endtask

	function int unsigned pending();
		return expected_q.size();
	endfunction
endclass

module tb_ordered_array_list_engine_unit;

	localparam int CAP = 16;
	localparam int RANDOM_ITEMS = 700;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [7:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [4:0]         found_position;
	logic signed [31:0] removed_value;
	logic [4:0]         list_length;

	list_scoreboard #(CAP) sb;

	int unsigned burst_left;
	int unsigned fill_goal;
	int unsigned stall_mode;
	int unsigned stall_hold;
	int unsigned cycle_ctr;

	ordered_array_list_engine_unit #(
		.CAPACITY(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_position(found_position),
		.removed_value(removed_value),
		.list_length(list_length)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// present one request word, hold it until taken, then maybe idle a while
	task send_word(logic [1:0] kind, logic [7:0] pos, logic signed [31:0] val);
		int unsigned gap;
		req_type <= kind;
		position <= pos;
		value    <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_request(kind, pos, val);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	function logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd7;
			5: return 32'sh5a5a_5a5a;
			default: return $urandom();
		endcase
	endfunction

	// mostly legal positions so the list fills and drains, plus edge and junk positions
	task pick_random_item(output logic [1:0] kind, output logic [7:0] pos,
		output logic signed [31:0] val);
		int unsigned roll;
		int unsigned cnt;
		int unsigned hi;
		cnt  = sb.count;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			kind = REQ_UNUSED;
		else if (roll < 23)
			kind = oale_pkg::REQ_LOCATE;
		else if ($urandom_range(0, 99) < ((cnt < fill_goal) ? 75 : 25))
			kind = oale_pkg::REQ_INSERT;
		else
			kind = oale_pkg::REQ_DELETE;
		val = pick_value();
		if (kind == oale_pkg::REQ_LOCATE && cnt > 0 && $urandom_range(0, 99) < 55)
			val = sb.entries[$urandom_range(0, cnt - 1)];
		hi   = (kind == oale_pkg::REQ_INSERT) ? cnt + 1 : cnt;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			pos = (hi == 0) ? 8'd1 : 8'($urandom_range(1, hi));
		else if (roll < 88)
			pos = 8'd0;
		else if (roll < 94)
			pos = 8'(hi + 1);
		else
			pos = 8'($urandom_range(0, 255));
	endtask

	// result side: check accepted words, stall on a pattern that changes now and then
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(oale_pkg::oale_res_t'{status, found_position, removed_value,
				list_length});
		cycle_ctr++;
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(64, 256);
		end else begin
			stall_hold--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 4) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= cycle_ctr[2];
		endcase
	end

	initial begin
		logic [1:0]         kind;
		logic [7:0]         pos;
		logic signed [31:0] val;
		int                 n;
		sb = new();
		burst_left = 0;
		fill_goal  = 8;
		stall_mode = 0;
		stall_hold = 0;
		cycle_ctr  = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= oale_pkg::REQ_INSERT;
		position  <= '0;
		value     <= '0;
		out_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and rejected requests
		send_word(oale_pkg::REQ_LOCATE, 8'd0, 32'sd0);
		send_word(oale_pkg::REQ_DELETE, 8'd1, 32'sd0);
		send_word(oale_pkg::REQ_INSERT, 8'd0, 32'sd5);
		send_word(oale_pkg::REQ_INSERT, 8'd2, 32'sd5);
		send_word(REQ_UNUSED, 8'd1, 32'sd5);
		// build a short list: append, front and middle inserts, a duplicate
		send_word(oale_pkg::REQ_INSERT, 8'd1, MIN_VAL);
		send_word(oale_pkg::REQ_INSERT, 8'd2, MAX_VAL);
		send_word(oale_pkg::REQ_INSERT, 8'd1, 32'sd7);
		send_word(oale_pkg::REQ_INSERT, 8'd2, -32'sd1);
		send_word(oale_pkg::REQ_INSERT, 8'd5, 32'sd7);
		// locate must return the first match and ignore the position
		send_word(oale_pkg::REQ_LOCATE, 8'hff, 32'sd7);
		send_word(oale_pkg::REQ_LOCATE, 8'd0, MAX_VAL);
		send_word(oale_pkg::REQ_LOCATE, 8'd0, 32'sd12345);
		send_word(oale_pkg::REQ_INSERT, 8'd255, 32'sd1);
		send_word(oale_pkg::REQ_DELETE, 8'd0, 32'sd0);
		send_word(oale_pkg::REQ_DELETE, 8'd6, 32'sd0);
		send_word(oale_pkg::REQ_DELETE, 8'd5, 32'sd0);
		send_word(oale_pkg::REQ_DELETE, 8'd1, 32'sd0);
		// fill up, then a bad position on a full list wins over the full status
		while (sb.count < CAP)
			send_word(oale_pkg::REQ_INSERT, 8'($urandom_range(1, sb.count + 1)),
				pick_value());
		send_word(oale_pkg::REQ_INSERT, 8'd18, 32'sd9);
		send_word(oale_pkg::REQ_INSERT, 8'd1, 32'sd9);
		send_word(oale_pkg::REQ_LOCATE, 8'd0, sb.entries[CAP-1]);
		send_word(oale_pkg::REQ_DELETE, 8'd16, 32'sd0);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// swing the target length between empty, full and in between
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: fill_goal = $urandom_range(0, 2);
					1: fill_goal = $urandom_range(CAP - 2, CAP + 1);
					default: fill_goal = $urandom_range(0, CAP);
				endcase
			end
			pick_random_item(kind, pos, val);
			send_word(kind, pos, val);
		end
		if (in_valid)
			in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * CAP + 8) @(posedge clk);

		$display("requests: %0d insert, %0d delete, %0d locate, %0d unused; peak length %0d",
			sb.kind_seen[oale_pkg::REQ_INSERT], sb.kind_seen[oale_pkg::REQ_DELETE],
			sb.kind_seen[oale_pkg::REQ_LOCATE], sb.kind_seen[REQ_UNUSED], sb.peak_len);
		$display("results: %0d checked (%0d ok, %0d bad position, %0d full, %0d missing), %0d errors",
			sb.checked, sb.status_seen[oale_pkg::ST_OK], sb.status_seen[oale_pkg::ST_BADPOS],
			sb.status_seen[oale_pkg::ST_FULL], sb.status_seen[oale_pkg::ST_MISSING],
			sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// generous ceiling on run time
	initial begin
		#2000000;
		$display("timeout with %0d result words outstanding", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ ordered_array_list_engine_unit.f @@
sv/oale_pkg.sv
sv/oale_ram.sv
sv/oale_ctrl.sv
sv/ordered_array_list_engine_unit.sv
sv/oale_checker.sv
tb/sv/tb_ordered_array_list_engine_unit.sv
